// ===== sv/lcsi_pkg.sv =====
// Package: shared constants and types for the LRU cache with spill index.
package lcsi_pkg;
  localparam int ENTRIES_DEF     = 64;
  localparam int ID_BITS_DEF     = 12;
  localparam int OFFSET_BITS_DEF = 34;
  localparam int CAP_W           = 7;
  localparam int LIMIT_W         = 34;
  localparam int SIZE_W          = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 34'h180000000;
  localparam logic [CAP_W-1:0]   CAP_RESET   = 7'd64;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_ADD = 1'b1;

  localparam logic [0:0] REG_CAPACITY = 1'd0;
  localparam logic [0:0] REG_LIMIT    = 1'd1;
endpackage

// ===== sv/lcsi_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module lcsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/lru_cache_with_spill_index.sv =====
// Top level: LRU directory of node IDs with a spill index and a scanning sequencer.
//
// Each item (get or add) is handled by a sequencer that walks the entry table
// one slot per cycle. Entry IDs, sizes and recency ranks sit in small RAMs with
// registered read. A search pass finds the matching ID, the first free slot,
// the occupancy and the least recent entry. The S_IDXRD and S_DECIDE states
// then fetch the victim and the spill index data. An add or a reload passes
// through S_VREAD for the limit check and the spill commit, then one update
// pass ages the entries before the result. A get hit ages the entries in a
// touch pass; a get not in the index and an overflow give their result with
// no update pass. The result then waits until it is taken, and the block
// returns to idle before the next item is accepted. in_stall is high from
// acceptance until the block is back in idle. The spill index is a 2**ID_BITS
// deep memory; its valid bits are swept clear after reset, and no item is
// accepted during the sweep. Configuration writes should be made only while
// the block is idle.
// Ranks are kept per slot: 0 is the most recent valid entry.
module lru_cache_with_spill_index
  import lcsi_pkg::*;
#(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cmd,
  input  logic [ID_BITS-1:0]     node_id,
  input  logic [SIZE_W-1:0]      record_size,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   hit,
  output logic                   found,
  output logic [OFFSET_BITS-1:0] load_offset,
  output logic                   evicted,
  output logic [ID_BITS-1:0]     evicted_id,
  output logic [OFFSET_BITS-1:0] spill_offset,
  output logic                   full_error
);
  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IDX_DEPTH = 1 << ID_BITS;
  localparam logic [SW:0] PASS_END = (SW+1)'(ENTRIES);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_IDXRD  = 9'b000001000,
    S_DECIDE = 9'b000010000,
    S_VREAD  = 9'b000100000,
    S_INSERT = 9'b001000000,
    S_TOUCH  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;

  // configuration
  logic [CAP_W-1:0]   capacity;
  logic [LIMIT_W-1:0] spill_limit;
  logic               cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAP_RESET;
      spill_limit <= LIMIT_RESET;
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_CAPACITY: if (paddr[2:0] == 3'd0) capacity <= pwdata[CAP_W-1:0];
        REG_LIMIT:    if (paddr[2:0] == 3'd0) spill_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == 4'd0) prdata = 64'(capacity);
    else if (paddr == 4'd8) prdata = 64'(spill_limit);
  end

  // entry table: valid bits in flops, ID, size and rank in RAMs
  logic [ENTRIES-1:0] ent_valid;
  logic [ENTRIES-1:0] rm_mask;
  logic               ent_we;
  logic [SW-1:0]      rd_slot, eid_raddr, pslot;
  logic [ID_BITS-1:0] eid_rdata;
  logic [SIZE_W-1:0]  esz_rdata;
  logic               ea_we;
  logic [SW-1:0]      ea_wdata, ea_rdata;

  // item registers
  logic               r_cmd;
  logic [ID_BITS-1:0] r_id;
  logic [SIZE_W-1:0]  r_size;
  logic [SW:0]        ptr;       // pass counter; slot ptr-1 is processed
  logic               proc;
  logic [SW-1:0]      match_slot, free_slot, victim_slot, ins_slot;
  logic               match_ok, free_ok, victim_ok, ins_ok;
  logic [SW-1:0]      match_age, victim_age;
  logic [CW-1:0]      occ;
  logic               do_victim;

  logic [OFFSET_BITS-1:0] spill_ptr;

  // spill index memory and its valid bits memory
  logic                   ix_we, iv_we;
  logic [ID_BITS-1:0]     ix_waddr, ix_raddr, iv_waddr;
  logic [OFFSET_BITS-1:0] ix_wdata, ix_rdata;
  logic [0:0]             iv_wdata, iv_rdata;
  logic [ID_BITS:0]       clr_cnt;

  lcsi_ram #(.WIDTH(OFFSET_BITS), .DEPTH(IDX_DEPTH)) u_ix (
    .clk(clk), .we(ix_we), .waddr(ix_waddr), .wdata(ix_wdata),
    .raddr(ix_raddr), .rdata(ix_rdata)
  );
  lcsi_ram #(.WIDTH(1), .DEPTH(IDX_DEPTH)) u_iv (
    .clk(clk), .we(iv_we), .waddr(iv_waddr), .wdata(iv_wdata),
    .raddr(ix_raddr), .rdata(iv_rdata)
  );

  lcsi_ram #(.WIDTH(ID_BITS), .DEPTH(ENTRIES)) u_eid (
    .clk(clk), .we(ent_we), .waddr(free_slot), .wdata(r_id),
    .raddr(eid_raddr), .rdata(eid_rdata)
  );
  lcsi_ram #(.WIDTH(SIZE_W), .DEPTH(ENTRIES)) u_esz (
    .clk(clk), .we(ent_we), .waddr(free_slot), .wdata(r_size),
    .raddr(victim_slot), .rdata(esz_rdata)
  );
  lcsi_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_eage (
    .clk(clk), .we(ea_we), .waddr(pslot), .wdata(ea_wdata),
    .raddr(rd_slot), .rdata(ea_rdata)
  );

  // effective capacity
  logic [CW-1:0] cap_eff;
  always_comb begin
    if (capacity == '0) cap_eff = CW'(1);
    else if (32'(capacity) > ENTRIES) cap_eff = CW'(ENTRIES);
    else cap_eff = CW'(capacity);
  end

  // shared add/compare unit for the spill limit check
  logic [LIMIT_W:0]       spill_sum;
  logic                   spill_over;
  logic [ID_BITS-1:0]     v_id;
  logic [SIZE_W-1:0]      v_size;
  assign spill_sum  = (LIMIT_W+1)'(spill_ptr) + (LIMIT_W+1)'(v_size);
  assign spill_over = do_victim && (spill_sum > (LIMIT_W+1)'(spill_limit));

  logic [CW-1:0] count_eff;
  assign count_eff = match_ok ? occ - CW'(1) : occ;

  // read one slot ahead, process the slot read in the previous cycle
  assign proc      = (ptr != '0);
  assign pslot     = SW'(ptr - (SW+1)'(1));
  assign rd_slot   = (ptr < PASS_END) ? SW'(ptr) : '0;
  assign eid_raddr = (state == S_IDXRD) ? victim_slot : rd_slot;
  assign ent_we    = (state == S_INSERT) && (ptr == PASS_END) && free_ok;

  // slots freed by this item, and the lowest free slot after the removals
  always_comb begin
    rm_mask = '0;
    if (match_ok) rm_mask[match_slot] = 1'b1;
    if (do_victim) rm_mask[victim_slot] = 1'b1;
    ins_ok   = free_ok;
    ins_slot = free_slot;
    if (match_ok && (!ins_ok || match_slot < ins_slot)) begin
      ins_ok   = 1'b1;
      ins_slot = match_slot;
    end
    if (do_victim && (!ins_ok || victim_slot < ins_slot)) begin
      ins_ok   = 1'b1;
      ins_slot = victim_slot;
    end
  end

  // rank updates; removals and the insert are folded into one pass since a
  // victim is always the oldest remaining entry
  always_comb begin
    ea_we    = 1'b0;
    ea_wdata = ea_rdata + SW'(1);
    if (proc && state == S_INSERT) begin
      if (ent_valid[pslot]) begin
        ea_we = 1'b1;
        if (match_ok && ea_rdata > match_age) ea_wdata = ea_rdata;
      end else if (free_ok && pslot == free_slot) begin
        ea_we    = 1'b1;
        ea_wdata = '0;
      end
    end else if (proc && state == S_TOUCH) begin
      if (pslot == match_slot) begin
        ea_we    = 1'b1;
        ea_wdata = '0;
      end else if (ent_valid[pslot] && ea_rdata < match_age) begin
        ea_we = 1'b1;
      end
    end
  end

  always_comb begin
    ix_we    = 1'b0;
    iv_we    = 1'b0;
    ix_waddr = v_id;
    iv_waddr = v_id;
    ix_wdata = spill_ptr;
    iv_wdata = 1'b1;
    ix_raddr = r_id;
    if (state == S_CLEAR) begin
      iv_we    = 1'b1;
      iv_waddr = clr_cnt[ID_BITS-1:0];
      iv_wdata = 1'b0;
    end else if (state == S_VREAD && do_victim && !spill_over) begin
      ix_we = 1'b1;
      iv_we = 1'b1;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      ent_valid <= '0;
      spill_ptr <= '0;
      out_valid <= 1'b0;
      ptr       <= '0;
      match_ok  <= 1'b0;
      do_victim <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (ID_BITS+1)'(IDX_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            r_cmd     <= cmd;
            r_id      <= node_id;
            r_size    <= record_size;
            ptr       <= '0;
            match_ok  <= 1'b0;
            free_ok   <= 1'b0;
            victim_ok <= 1'b0;
            occ       <= '0;
            do_victim <= 1'b0;
            hit <= 1'b0; found <= 1'b0; load_offset <= '0; evicted <= 1'b0;
            evicted_id <= '0; spill_offset <= '0; full_error <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // one slot per cycle: match, free slot, occupancy, oldest
          if (proc) begin
            if (ent_valid[pslot]) begin
              occ <= occ + CW'(1);
              if (eid_rdata == r_id && !match_ok) begin
                match_ok <= 1'b1; match_slot <= pslot; match_age <= ea_rdata;
              end else if (!victim_ok || ea_rdata >= victim_age) begin
                victim_ok <= 1'b1; victim_slot <= pslot; victim_age <= ea_rdata;
              end
            end else if (!free_ok) begin
              free_ok <= 1'b1; free_slot <= pslot;
            end
          end
          if (ptr == PASS_END) begin
            ptr   <= '0;
            state <= S_IDXRD;
          end else ptr <= ptr + 1'b1;
        end
        S_IDXRD: state <= S_DECIDE;   // victim ID and size are read
        S_DECIDE: begin
          v_id   <= eid_rdata;
          v_size <= esz_rdata;
          if (r_cmd == CMD_GET && match_ok) begin
            hit <= 1'b1; found <= 1'b1;
            state <= S_TOUCH;
          end else if (r_cmd == CMD_GET && !iv_rdata[0]) begin
            out_valid <= 1'b1; state <= S_OUT;
          end else begin
            if (r_cmd == CMD_GET) load_offset <= ix_rdata;
            do_victim <= (count_eff >= cap_eff) && victim_ok;
            state <= S_VREAD;
          end
        end
        S_VREAD: begin
          // limit check; the index write above is gated by the same decision
          if (spill_over) begin
            load_offset <= '0; full_error <= 1'b1;
            out_valid <= 1'b1; state <= S_OUT;
          end else begin
            found <= 1'b1; hit <= match_ok;
            if (do_victim) begin
              spill_ptr    <= spill_ptr + OFFSET_BITS'(v_size);
              evicted      <= 1'b1;
              evicted_id   <= v_id;
              spill_offset <= spill_ptr;
            end
            ent_valid <= ent_valid & ~rm_mask;
            free_ok   <= ins_ok;
            free_slot <= ins_slot;
            state     <= S_INSERT;
          end
        end
        S_INSERT: begin
          if (ptr == PASS_END) begin
            ptr <= '0;
            if (free_ok) ent_valid[free_slot] <= 1'b1;
            out_valid <= 1'b1; state <= S_OUT;
          end else ptr <= ptr + 1'b1;
        end
        S_TOUCH: begin
          if (ptr == PASS_END) begin
            ptr <= '0;
            out_valid <= 1'b1; state <= S_OUT;
          end else ptr <= ptr + 1'b1;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the entry a hit touches is in the cache
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_TOUCH) |-> ent_valid[match_slot]) else $error("touch of empty slot");
  // an error result carries no eviction
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && full_error) |-> (!evicted && !found)) else $error("dirty error result");
  // the spill pointer moves only on an eviction
  a_ptr_move: assert property (@(posedge clk) disable iff (rst)
    (state != S_VREAD) |=> $stable(spill_ptr)) else $error("spill pointer moved");
endmodule
